/* sv/pptb_pkg.sv */
// Shared types and constants for the light-pen pixel to board coordinate mapper.
`timescale 1ns / 1ps
package pptb_pkg;

    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 8;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [COLOR_W-1:0] PEN_RED_MIN = 8'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT_X     = 3'd0,
        CFG_TOP_LEFT_Y     = 3'd1,
        CFG_TOP_RIGHT_X    = 3'd2,
        CFG_TOP_RIGHT_Y    = 3'd3,
        CFG_BOTTOM_RIGHT_X = 3'd4,
        CFG_BOTTOM_RIGHT_Y = 3'd5,
        CFG_BOTTOM_LEFT_X  = 3'd6,
        CFG_BOTTOM_LEFT_Y  = 3'd7
    } t_cfg_idx;

    // Corner numbering: register of corner c is x at 2c, y at 2c+1.
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    localparam logic [COORD_W-1:0] CFG_RESET [NUM_REGS] = '{
        10'd0, 10'd0, 10'd639, 10'd0, 10'd639, 10'd479, 10'd0, 10'd479
    };

    typedef struct packed {
        logic [COORD_W-1:0] cam_col;
        logic [COORD_W-1:0] cam_row;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [COORD_W-1:0] board_col;
        logic [COORD_W-1:0] board_row;
    } t_board_out;

endpackage

/* sv/pptb_cell.sv */
// One bisection step for both axes: narrows each fraction interval by half.
`timescale 1ns / 1ps
module pptb_cell #(
    parameter int STEPS = 10,
    parameter int IDX   = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [pptb_pkg::COORD_W-1:0]          i_cx,
    input  logic [pptb_pkg::COORD_W-1:0]          i_cy,
    input  logic signed [pptb_pkg::COORD_W:0]     i_d   [2][4],
    input  logic [STEPS-1:0]                      i_lo  [2],
    input  logic [STEPS+pptb_pkg::COORD_W-1:0]    i_n   [2][4],
    output logic                                  o_valid,
    output logic [pptb_pkg::COORD_W-1:0]          o_cx,
    output logic [pptb_pkg::COORD_W-1:0]          o_cy,
    output logic [STEPS-1:0]                      o_lo  [2],
    output logic [STEPS+pptb_pkg::COORD_W-1:0]    o_n   [2][4]
);
    import pptb_pkg::*;

    localparam int NW = STEPS + COORD_W;
    localparam int XW = NW + 2;
    localparam int SH = STEPS - 1 - IDX;

    logic signed [XW-1:0]      w_sum  [2][4];
    logic [NW-1:0]             w_mid  [2][4];
    logic [COORD_W-1:0]        w_pt   [2][4];
    logic signed [COORD_W:0]   w_t1   [2];
    logic signed [COORD_W:0]   w_t2   [2];
    logic signed [COORD_W:0]   w_t3   [2];
    logic signed [COORD_W:0]   w_t4   [2];
    logic signed [2*COORD_W+1:0] w_p1 [2];
    logic signed [2*COORD_W+1:0] w_p2 [2];
    logic signed [2*COORD_W+2:0] w_cross [2];
    logic                      w_keep [2];
    logic [STEPS-1:0]          w_mid_k [2];

    // Edge numerator at the midpoint: lower numerator plus half the interval times delta.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int j = 0; j < 4; j++) begin
                w_sum[a][j] = $signed({2'b00, i_n[a][j]}) + (XW'(i_d[a][j]) <<< SH);
                w_mid[a][j] = w_sum[a][j][NW-1:0];
                w_pt[a][j]  = w_mid[a][j][NW-1:STEPS];
            end
            // Coordinates order: A.x, A.y, B.x, B.y
            w_t1[a] = $signed({1'b0, w_pt[a][2]}) - $signed({1'b0, w_pt[a][0]});
            w_t2[a] = $signed({1'b0, i_cy})       - $signed({1'b0, w_pt[a][3]});
            w_t3[a] = $signed({1'b0, w_pt[a][3]}) - $signed({1'b0, w_pt[a][1]});
            w_t4[a] = $signed({1'b0, i_cx})       - $signed({1'b0, w_pt[a][2]});
            w_p1[a] = w_t1[a] * w_t2[a];
            w_p2[a] = w_t3[a] * w_t4[a];
            w_cross[a] = (2*COORD_W+3)'(w_p1[a]) - (2*COORD_W+3)'(w_p2[a]);
            w_keep[a]  = w_cross[a] > 0;
            w_mid_k[a] = i_lo[a] + (STEPS'(1) << SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // Positive cross: hold the lower bound; otherwise advance it to the midpoint.
    always_ff @(posedge i_clk) begin
        o_cx <= i_cx;
        o_cy <= i_cy;
        for (int a = 0; a < 2; a++) begin
            o_lo[a] <= w_keep[a] ? i_lo[a] : w_mid_k[a];
            for (int j = 0; j < 4; j++) begin
                o_n[a][j] <= w_keep[a] ? i_n[a][j] : w_mid[a][j];
            end
        end
    end

endmodule

/* sv/pptb_scale.sv */
// Output stage: scales the two fractions to board column and row.
`timescale 1ns / 1ps
module pptb_scale #(
    parameter int BOARD_WIDTH  = 800,
    parameter int BOARD_HEIGHT = 600,
    parameter int STEPS        = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [STEPS-1:0]         i_kx,
    input  logic [STEPS-1:0]         i_ky,
    output logic                     o_strobe,
    output pptb_pkg::t_board_out     o_result
);
    import pptb_pkg::*;

    localparam int DW  = 14;
    localparam int PXW = DW + STEPS;
    localparam int PYW = DW + STEPS + 1;

    logic [PXW-1:0]   w_col_prod;
    logic [STEPS:0]   w_ky_inv;
    logic [PYW-1:0]   w_row_prod;
    logic [DW:0]      w_row_full;
    logic [DW:0]      w_row_clamp;

    always_comb begin
        w_col_prod = PXW'(BOARD_WIDTH) * PXW'(i_kx);
        w_ky_inv   = ((STEPS+1)'(1) << STEPS) - {1'b0, i_ky};
        w_row_prod = PYW'(BOARD_HEIGHT) * PYW'(w_ky_inv);
        w_row_full = w_row_prod[PYW-1:STEPS];
        // A fraction of zero lands one past the last row: pull it back.
        if (w_row_full > (DW+1)'(BOARD_HEIGHT - 1)) begin
            w_row_clamp = (DW+1)'(BOARD_HEIGHT - 1);
        end else begin
            w_row_clamp = w_row_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.board_col <= w_col_prod[STEPS+COORD_W-1:STEPS];
        o_result.board_row <= w_row_clamp[COORD_W-1:0];
    end

endmodule

/* sv/pen_pixel_to_board_coords.sv */
// Top level: pen pixel detection, bisection cell chain and board scaling.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+----------------------------
//  pixel    | in        | start, busy                  | i_pixel (t_pix_in)
//  result   | out       | o_strobe (one cycle, no hold)| o_result (t_board_out)
//  config   | in        | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle; busy stays low. A pen pixel gives its result
// through one registered cell per bisection step, both axes side by side in each
// cell, then one registered scaling stage. Other pixels give nothing.
// Reset clears the valid chain and loads the default corners; config writes are always accepted.
// The receiver cannot stall, so nothing ever waits inside the chain.
`timescale 1ns / 1ps
module pen_pixel_to_board_coords #(
    parameter int BOARD_WIDTH  = 800,
    parameter int BOARD_HEIGHT = 600,
    parameter int BISECT_STEPS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pptb_pkg::t_pix_in                  i_pixel,
    output logic                               o_strobe,
    output pptb_pkg::t_board_out               o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pptb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pptb_pkg::COORD_W-1:0]       i_cfg_data
);
    import pptb_pkg::*;

    localparam int S  = BISECT_STEPS;
    localparam int NW = S + COORD_W;

    // Edge endpoints per axis: A runs CA0 -> CA1, B runs CB0 -> CB1.
    localparam int CA0 [2] = '{CORNER_TL, CORNER_BL};
    localparam int CA1 [2] = '{CORNER_TR, CORNER_TL};
    localparam int CB0 [2] = '{CORNER_BL, CORNER_BR};
    localparam int CB1 [2] = '{CORNER_BR, CORNER_TR};

    logic [COORD_W-1:0] r_cfg [NUM_REGS];

    logic                    w_pen;
    logic                    w_take;
    logic signed [COORD_W:0] w_d [2][4];

    logic                 c_valid [S+1];
    logic [COORD_W-1:0]   c_cx    [S+1];
    logic [COORD_W-1:0]   c_cy    [S+1];
    logic [S-1:0]         c_lo    [S+1][2];
    logic [NW-1:0]        c_n     [S+1][2][4];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_pen  = (i_pixel.red > PEN_RED_MIN) &&
                    ({1'b0, i_pixel.red} > ({1'b0, i_pixel.green} + {1'b0, i_pixel.blue}));
    assign w_take = start && !busy && w_pen;

    // Entry of the chain: lower bound zero, numerators at the start corners.
    assign c_valid[0] = w_take;
    assign c_cx[0]    = i_pixel.cam_col;
    assign c_cy[0]    = i_pixel.cam_row;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        assign c_lo[0][a] = '0;
        for (genvar j = 0; j < 4; j++) begin : g_coord
            localparam int C0 = (j < 2) ? CA0[a] : CB0[a];
            localparam int C1 = (j < 2) ? CA1[a] : CB1[a];
            localparam int R0 = 2 * C0 + (j % 2);
            localparam int R1 = 2 * C1 + (j % 2);
            assign w_d[a][j]  = $signed({1'b0, r_cfg[R1]}) - $signed({1'b0, r_cfg[R0]});
            assign c_n[0][a][j] = {r_cfg[R0], {S{1'b0}}};
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_cell
        pptb_cell #(
            .STEPS (S),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_cx    (c_cx[k]),
            .i_cy    (c_cy[k]),
            .i_d     (w_d),
            .i_lo    (c_lo[k]),
            .i_n     (c_n[k]),
            .o_valid (c_valid[k+1]),
            .o_cx    (c_cx[k+1]),
            .o_cy    (c_cy[k+1]),
            .o_lo    (c_lo[k+1]),
            .o_n     (c_n[k+1])
        );
    end

    pptb_scale #(
        .BOARD_WIDTH  (BOARD_WIDTH),
        .BOARD_HEIGHT (BOARD_HEIGHT),
        .STEPS        (S)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[S]),
        .i_kx     (c_lo[S][0]),
        .i_ky     (c_lo[S][1]),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_strobe_from_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_take, S + 1))
        else $error("result strobe without a pen pixel taken earlier");

    a_pen_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##(S + 1) o_strobe)
        else $error("pen pixel lost in the cell chain");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((BOARD_WIDTH >= 1024) || (o_result.board_col < 10'(BOARD_WIDTH))))
        else $error("board column beyond board width");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((BOARD_HEIGHT >= 1024) || (o_result.board_row < 10'(BOARD_HEIGHT))))
        else $error("board row not clamped to the last row");
`endif

endmodule

/* tb/pen_board_checker.sv */
// Checker for the pen pixel mapper: predicts board points and compares the result stream.
`timescale 1ns / 1ps
module pen_board_checker #(
    parameter int BOARD_WIDTH  = 800,
    parameter int BOARD_HEIGHT = 600,
    parameter int BISECT_STEPS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  pptb_pkg::t_pix_in              i_pixel,
    input  logic                           i_strobe,
    input  pptb_pkg::t_board_out           i_result,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pptb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pptb_pkg::COORD_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import pptb_pkg::*;

    localparam longint FRAC_ONE = longint'(1) << BISECT_STEPS;

    logic [COORD_W-1:0] cal [NUM_REGS];
    t_board_out         pending_points [$];
    int                 fail_count = 0;
    int                 pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Point at fraction k along corner c0 -> c1; axis 0 is x, 1 is y.
    function automatic longint corner_lerp(int c0, int c1, int axis, longint k);
        return (longint'(cal[2*c0+axis]) * (FRAC_ONE - k) +
                longint'(cal[2*c1+axis]) * k) >>> BISECT_STEPS;
    endfunction

    // Bisect along edges a0->a1 and b0->b1; narrow toward the side where the turn is positive.
    function automatic longint sweep_fraction(int a0, int a1, int b0, int b1,
                                              longint px, longint py);
        longint lo, hi, mid, ax, ay, bx, by, turn;
        lo = 0;
        hi = FRAC_ONE;
        for (int s = 0; s < BISECT_STEPS; s++) begin
            mid  = (lo + hi) >>> 1;
            ax   = corner_lerp(a0, a1, 0, mid);
            ay   = corner_lerp(a0, a1, 1, mid);
            bx   = corner_lerp(b0, b1, 0, mid);
            by   = corner_lerp(b0, b1, 1, mid);
            turn = (bx - ax) * (py - by) - (by - ay) * (px - bx);
            if (turn > 0) hi = mid;
            else          lo = mid;
        end
        return lo;
    endfunction

    function automatic t_board_out board_point(t_pix_in p);
        longint     kx, ky, col, row;
        t_board_out pt;
        kx  = sweep_fraction(CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BR,
                             longint'(p.cam_col), longint'(p.cam_row));
        ky  = sweep_fraction(CORNER_BL, CORNER_TL, CORNER_BR, CORNER_TR,
                             longint'(p.cam_col), longint'(p.cam_row));
        col = (BOARD_WIDTH * kx) >>> BISECT_STEPS;
        row = (BOARD_HEIGHT * (FRAC_ONE - ky)) >>> BISECT_STEPS;
        // ky of zero lands one past the last row
        if (row > BOARD_HEIGHT - 1) row = BOARD_HEIGHT - 1;
        pt.board_col = col[COORD_W-1:0];
        pt.board_row = row[COORD_W-1:0];
        return pt;
    endfunction

    function automatic bit is_pen(t_pix_in p);
        return p.red > PEN_RED_MIN && int'(p.red) > int'(p.green) + int'(p.blue);
    endfunction

    always @(posedge i_clk) begin : watch
        t_board_out want;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) cal[r] = CFG_RESET[r];
            pending_points.delete();
        end else begin
            if (i_strobe) begin
                if (pending_points.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result col %0d row %0d",
                                 $realtime, i_result.board_col, i_result.board_row);
                end else begin
                    want = pending_points.pop_front();
                    if (want.board_col !== i_result.board_col ||
                        want.board_row !== i_result.board_row) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: expected col %0d row %0d, got col %0d row %0d",
                                     $realtime, want.board_col, want.board_row,
                                     i_result.board_col, i_result.board_row);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) cal[i_cfg_index] = i_cfg_data;
            if (i_start && !i_busy && is_pen(i_pixel))
                pending_points.push_back(board_point(i_pixel));
        end
        pending_count = pending_points.size();
    end

endmodule

/* tb/testbench.sv */
// Testbench top: drives pixels and calibration writes into the mapper and gives the verdict.
`timescale 1ns / 1ps
module testbench;
    import pptb_pkg::*;

    localparam int BOARD_WIDTH  = 800;
    localparam int BOARD_HEIGHT = 600;
    localparam int BISECT_STEPS = 10;
    localparam int SETTLE       = BISECT_STEPS + 4;
    localparam int PHASE_PENS   = 145;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    t_pix_in            pixel = '0;
    logic               cfg_valid = 1'b0;
    t_cfg_idx           cfg_index = CFG_TOP_LEFT_X;
    logic [COORD_W-1:0] cfg_data = '0;
    logic               busy;
    logic               strobe;
    logic               cfg_ready;
    t_board_out         result;
    int                 fail_count;
    int                 pending;
    int                 idle_pct = 0;
    logic [COORD_W-1:0] corners [NUM_REGS];

    pen_pixel_to_board_coords #(
        .BOARD_WIDTH (BOARD_WIDTH),
        .BOARD_HEIGHT(BOARD_HEIGHT),
        .BISECT_STEPS(BISECT_STEPS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (pixel),
        .o_strobe   (strobe),
        .o_result   (result),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    pen_board_checker #(
        .BOARD_WIDTH (BOARD_WIDTH),
        .BOARD_HEIGHT(BOARD_HEIGHT),
        .BISECT_STEPS(BISECT_STEPS)
    ) point_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_pixel     (pixel),
        .i_strobe    (strobe),
        .i_result    (result),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_pix_in pix(int col, int row, int r, int g, int b);
        t_pix_in p;
        p.cam_col = COORD_W'(col);
        p.cam_row = COORD_W'(row);
        p.red     = COLOR_W'(r);
        p.green   = COLOR_W'(g);
        p.blue    = COLOR_W'(b);
        return p;
    endfunction

    function automatic t_pix_in random_pixel(bit pen);
        t_pix_in p;
        int      c;
        p.cam_col = COORD_W'($urandom_range(1023));
        p.cam_row = COORD_W'($urandom_range(1023));
        // land some pixels right around a calibrated corner
        if ($urandom_range(9) == 0) begin
            c = $urandom_range(3);
            p.cam_col = COORD_W'(corners[2*c] + $urandom_range(6) - 3);
            p.cam_row = COORD_W'(corners[2*c+1] + $urandom_range(6) - 3);
        end
        if (pen) begin
            p.red   = COLOR_W'($urandom_range(255, 201));
            p.green = COLOR_W'($urandom_range(p.red - 1));
            p.blue  = COLOR_W'($urandom_range(p.red - 1 - p.green));
        end else if ($urandom_range(1)) begin
            p.red   = COLOR_W'($urandom_range(200));
            p.green = COLOR_W'($urandom);
            p.blue  = COLOR_W'($urandom);
        end else begin
            // bright red but not above green plus blue
            p.red   = COLOR_W'($urandom_range(255, 201));
            p.green = COLOR_W'($urandom_range(p.red));
            p.blue  = p.red - p.green;
        end
        return p;
    endfunction

    task automatic send_pixel(input t_pix_in p);
        start <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (busy);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected point is back and the chain is empty.
    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_corners();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= t_cfg_idx'(r);
            cfg_data  <= corners[r];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int pens);
        int sent;
        sent = 0;
        while (sent < pens) begin
            if ($urandom_range(3) == 0) begin
                send_pixel(random_pixel(1'b0));
            end else begin
                send_pixel(random_pixel(1'b1));
                sent++;
            end
        end
        settle();
    endtask

    initial begin
        t_pix_in directed [$];
        int      pcts [3];
        bit      xhi, yhi;
        pcts = '{0, 72, 30};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < NUM_REGS; r++) corners[r] = CFG_RESET[r];

        // Directed pass on the reset calibration: color threshold and field extremes.
        directed.push_back(pix(0, 0, 201, 0, 0));
        directed.push_back(pix(0, 0, 200, 0, 0));
        directed.push_back(pix(1023, 1023, 255, 0, 0));
        directed.push_back(pix(639, 479, 255, 127, 127));
        directed.push_back(pix(639, 479, 255, 128, 127));
        directed.push_back(pix(0, 479, 255, 0, 254));
        directed.push_back(pix(320, 479, 230, 100, 0));
        directed.push_back(pix(320, 240, 255, 255, 255));
        directed.push_back(pix(320, 240, 0, 0, 0));
        directed.push_back(pix(320, 240, 255, 0, 0));
        directed.push_back(pix(1023, 0, 210, 100, 100));
        directed.push_back(pix(0, 1023, 255, 254, 0));
        directed.push_back(pix(639, 0, 255, 0, 0));
        directed.push_back(pix(512, 512, 255, 200, 54));
        directed.push_back(pix(700, 300, 201, 200, 0));
        directed.push_back(pix(100, 600, 255, 0, 0));
        directed.push_back(pix(640, 480, 202, 1, 0));
        directed.push_back(pix(1, 478, 255, 0, 0));
        foreach (directed[i]) send_pixel(directed[i]);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: corners = '{10'd0, 10'd0, 10'd639, 10'd0, 10'd639, 10'd479, 10'd0, 10'd479};
                1: corners = '{10'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023};
                2: corners = '{default: 10'd0};
                3: corners = '{default: 10'd1023};
                // corners mirrored through the center: the calibration turned by half a turn
                4: corners = '{10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0};
                6: for (int r = 0; r < NUM_REGS; r++) corners[r] = COORD_W'($urandom);
                default: begin
                    for (int c = 0; c < 4; c++) begin
                        xhi = (c == CORNER_TR || c == CORNER_BR);
                        yhi = (c == CORNER_BR || c == CORNER_BL);
                        corners[2*c]   = COORD_W'(xhi ? $urandom_range(1023, 800)
                                                      : $urandom_range(200));
                        corners[2*c+1] = COORD_W'(yhi ? $urandom_range(1023, 800)
                                                      : $urandom_range(200));
                    end
                end
            endcase
            load_corners();
            idle_pct = pcts[ph % 3];
            run_phase(PHASE_PENS);
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
sv/pptb_pkg.sv
sv/pptb_cell.sv
sv/pptb_scale.sv
sv/pen_pixel_to_board_coords.sv
tb/pen_board_checker.sv
tb/testbench.sv
